@@ src/dccs_pkg.sv @@
`timescale 1ns / 1ps

package dccs_pkg;

    localparam int unsigned CmdWidth = 16;
    localparam int unsigned RegWidth = 15;
    localparam int unsigned CfgIdxWidth = 2;

    // register map of the configuration port
    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_TURN_LIMIT  = 2'd1,
        CFG_SLEW_STEP   = 2'd2
    } t_cfg_idx;

    localparam logic [RegWidth-1:0] SpeedLimitReset = 15'd6144;  // 1.5
    localparam logic [RegWidth-1:0] TurnLimitReset  = 15'd8192;  // 2.0
    localparam logic [RegWidth-1:0] SlewStepReset   = 15'd614;   // about 0.15

    // one drive command, signed q3.12
    typedef struct packed {
        logic signed [CmdWidth-1:0] turn;
        logic signed [CmdWidth-1:0] speed;
    } t_cmd;

endpackage

@@ src/drive_command_clamp_slew_limiter_unit.sv @@
`timescale 1ns / 1ps

// channel   | dir | tdata (low bit up)                      | handshake
// s_axis    | in  | target_speed[15:0], target_turn[31:16]  | i_s_axis_tvalid / o_s_axis_tready
// m_axis    | out | speed_out[15:0], turn_out[31:16]        | o_m_axis_tvalid / i_m_axis_tready
// cfg       | in  | index 0 speed_limit, 1 turn_limit, 2 slew_step (15 bits) | i_cfg_wr_en
//
// two register stages: the request is clamped and shaped on the way into the input
// register, then slewed against the held values on the way into the held registers,
// which are also the result register. one request per cycle while the result is not stalled.
// synchronous active-low reset clears both stage valids, the held values to zero and
// the configuration registers to their defaults. a stalled result holds the held
// registers; the input register still takes one more request while the result waits.

module drive_command_clamp_slew_limiter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_wr_en,
    input  logic [dccs_pkg::CfgIdxWidth-1:0]     i_cfg_idx,
    input  logic [dccs_pkg::RegWidth-1:0]        i_cfg_data,
    // request stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [31:0]                          i_s_axis_tdata,   // target_speed, target_turn
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [31:0]                          o_m_axis_tdata    // speed_out, turn_out
);
    import dccs_pkg::*;

    // configuration registers
    logic [RegWidth-1:0] r_speed_limit;
    logic [RegWidth-1:0] r_turn_limit;
    logic [RegWidth-1:0] r_slew_step;

    // input stage holds the already clamped and raised target
    logic r_in_valid;
    t_cmd r_target;
    t_cmd n_target;

    // held values double as the result register
    logic                       r_out_valid;
    logic signed [CmdWidth-1:0] r_held_speed;
    logic signed [CmdWidth-1:0] r_held_turn;
    logic signed [CmdWidth-1:0] n_held_speed;
    logic signed [CmdWidth-1:0] n_held_turn;

    t_cmd in_cmd;
    logic advance;
    logic s_accept;
    logic m_accept;

    // speed in the low half, turn in the high half
    assign in_cmd = i_s_axis_tdata;

    // move the input stage on when the result slot is free or being emptied
    assign m_accept        = o_m_axis_tvalid & i_m_axis_tready;
    assign advance         = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | advance;
    assign s_accept        = i_s_axis_tvalid & o_s_axis_tready;

    dccs_shape u_shape (
        .i_target      (in_cmd),
        .i_speed_limit (r_speed_limit),
        .i_turn_limit  (r_turn_limit),
        .o_shaped      (n_target)
    );

    dccs_slew u_slew_speed (
        .i_target (r_target.speed),
        .i_held   (r_held_speed),
        .i_step   (r_slew_step),
        .o_next   (n_held_speed)
    );

    dccs_slew u_slew_turn (
        .i_target (r_target.turn),
        .i_held   (r_held_turn),
        .i_step   (r_slew_step),
        .o_next   (n_held_turn)
    );

    // configuration writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= SpeedLimitReset;
            r_turn_limit  <= TurnLimitReset;
            r_slew_step   <= SlewStepReset;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                CFG_TURN_LIMIT:  r_turn_limit  <= i_cfg_data;
                CFG_SLEW_STEP:   r_slew_step   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_target <= n_target;
        end
    end

    // slew stage and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_held_speed <= '0;
            r_held_turn  <= '0;
        end else begin
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_held_speed <= n_held_speed;
                r_held_turn  <= n_held_turn;
            end else if (m_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_held_turn, r_held_speed};

endmodule

@@ src/dccs_shape.sv @@
`timescale 1ns / 1ps

module dccs_shape (
    input  dccs_pkg::t_cmd                    i_target,
    input  logic [dccs_pkg::RegWidth-1:0]     i_speed_limit,
    input  logic [dccs_pkg::RegWidth-1:0]     i_turn_limit,
    output dccs_pkg::t_cmd                    o_shaped
);
    import dccs_pkg::*;

    // clamp to +/- limit, the most negative code lands on -limit
    function automatic logic signed [CmdWidth:0] clamp_mag(
        input logic signed [CmdWidth-1:0] v,
        input logic [RegWidth-1:0]        lim
    );
        logic signed [CmdWidth:0] wide;
        logic signed [CmdWidth:0] lim_s;
        logic signed [CmdWidth:0] mag;
        wide  = {v[CmdWidth-1], v};
        lim_s = {2'b00, lim};
        mag   = wide[CmdWidth] ? -wide : wide;
        if (mag > lim_s) begin
            clamp_mag = wide[CmdWidth] ? -lim_s : lim_s;
        end else begin
            clamp_mag = wide;
        end
    endfunction

    logic signed [CmdWidth:0] turn_c;
    logic signed [CmdWidth:0] speed_c;
    logic [CmdWidth:0]        turn_mag;
    logic [CmdWidth:0]        speed_mag2;
    logic [CmdWidth:0]        half;
    logic signed [CmdWidth:0] speed_r;

    always_comb begin
        turn_c     = clamp_mag(i_target.turn, i_turn_limit);
        speed_c    = clamp_mag(i_target.speed, i_speed_limit);
        turn_mag   = turn_c[CmdWidth] ? unsigned'(-turn_c) : unsigned'(turn_c);
        speed_mag2 = (speed_c[CmdWidth] ? unsigned'(-speed_c) : unsigned'(speed_c)) << 1;
        // half the turn magnitude rounded up
        half       = (turn_mag + (CmdWidth+1)'(1)) >> 1;
        speed_r    = speed_c;
        if (speed_mag2 < turn_mag) begin
            // zero speed counts as positive
            speed_r = speed_c[CmdWidth] ? -signed'(half) : signed'(half);
        end
        o_shaped.turn  = turn_c[CmdWidth-1:0];
        o_shaped.speed = speed_r[CmdWidth-1:0];
    end

endmodule

@@ src/dccs_slew.sv @@
`timescale 1ns / 1ps

module dccs_slew (
    input  logic signed [dccs_pkg::CmdWidth-1:0] i_target,
    input  logic signed [dccs_pkg::CmdWidth-1:0] i_held,
    input  logic [dccs_pkg::RegWidth-1:0]        i_step,
    output logic signed [dccs_pkg::CmdWidth-1:0] o_next
);
    import dccs_pkg::*;

    logic signed [CmdWidth+1:0] diff;
    logic signed [CmdWidth+1:0] gap;
    logic signed [CmdWidth+1:0] step_s;
    logic signed [CmdWidth+1:0] moved;

    always_comb begin
        diff   = {{2{i_target[CmdWidth-1]}}, i_target} - {{2{i_held[CmdWidth-1]}}, i_held};
        gap    = diff[CmdWidth+1] ? -diff : diff;
        step_s = {3'b000, i_step};
        // a full step toward the target stays between held and target
        moved  = diff[CmdWidth+1] ? {{2{i_held[CmdWidth-1]}}, i_held} - step_s
                                  : {{2{i_held[CmdWidth-1]}}, i_held} + step_s;
        if (gap < step_s) begin
            o_next = i_target;
        end else begin
            o_next = moved[CmdWidth-1:0];
        end
    end

endmodule
